// ===== hdl/ncrb_pkg.sv =====
// ncrb_pkg: shared types, constants and helpers of the newton cubic root basin block
// no dependencies; imported by the interfaces and every module of the block
package ncrb_pkg;

	localparam int COL_W = 12;
	localparam int ROW_W = 12;
	localparam int RES_W = 2;
	localparam int MAX_COLUMNS = 4096;
	localparam int MAX_ROWS = 4096;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_X_MIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_X_STEP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TOL = 3'd5;

	localparam logic signed [31:0] RST_X_MIN = -32'sd536870912;
	localparam logic signed [31:0] RST_Y_MIN = -32'sd536870912;
	localparam logic [30:0] RST_X_STEP = 31'd262144;
	localparam logic [30:0] RST_Y_STEP = 31'd262144;
	localparam logic [15:0] RST_MAX_ITER = 16'd64;
	localparam logic [15:0] RST_TOL = 16'd268;

	localparam logic [RES_W-1:0] RES_NONE = 2'd0;
	localparam logic [RES_W-1:0] RES_ROOT1 = 2'd1;
	localparam logic [RES_W-1:0] RES_ROOT2 = 2'd2;
	localparam logic [RES_W-1:0] RES_ROOT3 = 2'd3;

	localparam logic signed [43:0] Q_ONE = 44'sd268435456;
	localparam logic signed [31:0] ROOT_RE [3] = '{32'sd268435456, -32'sd134217728,
		-32'sd134217728};
	localparam logic signed [31:0] ROOT_IM [3] = '{32'sd0, 32'sd232471923, -32'sd232471923};

	localparam int QUOT_BITS = 36;
	localparam logic [QUOT_BITS:0] QUOT_CAP = {1'b1, {QUOT_BITS{1'b0}}};

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);

	localparam logic signed [44:0] Q_MAX_W = 45'sd2147483647;
	localparam logic signed [44:0] Q_MIN_W = -45'sd2147483648;

	typedef struct packed {
		logic signed [31:0] x_min;
		logic signed [31:0] y_min;
		logic [30:0] x_step;
		logic [30:0] y_step;
		logic [15:0] max_iterations;
		logic [15:0] tolerance;
	} ncrb_cfg_t;

	typedef struct packed {
		logic signed [31:0] x0;
		logic signed [31:0] y0;
		logic skip;
	} ncrb_job_t;

	function automatic logic signed [31:0] sat32(input logic signed [44:0] v);
		if (v > Q_MAX_W) return 32'sh7fffffff;
		if (v < Q_MIN_W) return 32'sh80000000;
		return v[31:0];
	endfunction

endpackage

// ===== hdl/ncrb_ifs.sv =====
// ncrb_ifs: valid/ready channels of the block, pixel in and basin result out
// depends on ncrb_pkg for field widths
interface ncrb_pix_if import ncrb_pkg::*; ();
	logic valid;
	logic ready;
	logic [COL_W-1:0] col;
	logic [ROW_W-1:0] row;
	modport source(output valid, col, row, input ready);
	modport sink(input valid, col, row, output ready);
endinterface

interface ncrb_res_if import ncrb_pkg::*; ();
	logic valid;
	logic ready;
	logic [RES_W-1:0] root_index;
	modport source(output valid, root_index, input ready);
	modport sink(input valid, root_index, output ready);
endinterface

// ===== hdl/ncrb_front.sv =====
// ncrb_front: takes pixel beats, maps them to a saturated Q4.28 start point
// depends on ncrb_pkg and ncrb_pix_if
module ncrb_front import ncrb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  ncrb_cfg_t cfg,
	ncrb_pix_if.sink pix,
	output logic job_valid,
	input  logic job_ready,
	output ncrb_job_t job
);
	logic valid_s1;
	ncrb_job_t job_s1;
	logic [42:0] px;
	logic [42:0] py;
	logic signed [44:0] sx;
	logic signed [44:0] sy;

	assign pix.ready = !valid_s1 || job_ready;
	assign job_valid = valid_s1;
	assign job = job_s1;

	always_comb begin
		px = 43'(pix.col) * 43'(cfg.x_step);
		py = 43'(pix.row) * 43'(cfg.y_step);
		sx = 45'(cfg.x_min) + $signed({2'b00, px});
		sy = 45'(cfg.y_min) + $signed({2'b00, py});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix.valid && pix.ready) begin
			valid_s1 <= 1'b1;
		end else if (job_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix.valid && pix.ready) begin
			job_s1.x0 <= sat32(sx);
			job_s1.y0 <= sat32(sy);
			job_s1.skip <= (32'(pix.col) >= MAX_COLUMNS) || (32'(pix.row) >= MAX_ROWS);
		end
	end
endmodule

// ===== hdl/ncrb_fifo.sv =====
// ncrb_fifo: short job queue between the front end and the newton engine
// depends on ncrb_pkg for the job type and depth
module ncrb_fifo import ncrb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  ncrb_job_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output ncrb_job_t pop_data
);
	ncrb_job_t mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0] cnt_q;
	logic push;
	logic pop;

	assign push_ready = cnt_q != (FIFO_AW+1)'(FIFO_DEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_data = mem_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end
endmodule

// ===== hdl/ncrb_core.sv =====
// ncrb_core: newton iteration engine, shared 42x21 multiplier and two serial dividers
// depends on ncrb_pkg and ncrb_res_if
module ncrb_core import ncrb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  ncrb_cfg_t cfg,
	input  logic job_valid,
	output logic job_ready,
	input  ncrb_job_t job,
	ncrb_res_if.source res
);
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_INIT = 4'd1;
	localparam logic [3:0] ST_TOP = 4'd2;
	localparam logic [3:0] ST_MUL = 4'd3;
	localparam logic [3:0] ST_DINIT = 4'd4;
	localparam logic [3:0] ST_DIV = 4'd5;
	localparam logic [3:0] ST_DRND = 4'd6;
	localparam logic [3:0] ST_UPD = 4'd7;
	localparam logic [3:0] ST_CHK1 = 4'd8;
	localparam logic [3:0] ST_CHK2 = 4'd9;
	localparam logic [3:0] ST_DONE = 4'd10;

	localparam logic [3:0] LAST_STEP = 4'd12;
	localparam logic [1:0] PH_LO = 2'd0;
	localparam logic [1:0] PH_HI = 2'd1;
	localparam logic [83:0] RND27 = 84'd1 << 26;
	localparam logic [83:0] RND28 = 84'd1 << 27;

	logic [3:0] state_q;
	logic [3:0] step_q;
	logic [1:0] phase_q;
	logic [5:0] cnt_q;
	logic [15:0] iter_q;
	logic res_valid_q;
	logic [RES_W-1:0] res_data_q;
	logic [RES_W-1:0] result_q;
	logic res_load;

	logic signed [31:0] x_q, y_q;
	logic [31:0] tol2_q;
	logic signed [43:0] t_q;
	logic signed [37:0] z2r_q, z2i_q;
	logic signed [39:0] dr_q, di_q;
	logic signed [41:0] fr_q, fi_q;
	logic signed [81:0] acc_q, nr_q, ni_q;
	logic [79:0] den_q;
	logic [83:0] prod_q;

	logic [79:0] remx_q, remy_q;
	logic [7:0] shx_q, shy_q;
	logic [QUOT_BITS:0] qx_q, qy_q;
	logic capx_q, capy_q, negx_q, negy_q;

	logic [15:0] ux_q [3];
	logic [15:0] uy_q [3];
	logic [2:0] ok_q;

	logic signed [41:0] op_a, op_b;
	logic [41:0] a_mag, b_mag;
	logic [20:0] dig;
	logic [62:0] pp;
	logic psign;
	logic [83:0] rnd_sum;
	logic [43:0] r_mag;
	logic signed [43:0] r_s;
	logic signed [81:0] p_s;

	logic signed [81:0] nmx, nmy;
	logic [80:0] r2x, r2y;
	logic gex, gey;
	logic signed [44:0] qsx, qsy;

	logic [15:0] ux_c [3];
	logic [15:0] uy_c [3];
	logic [2:0] ok_c;
	logic signed [33:0] dx, dy;
	logic [33:0] mx, my;
	logic [32:0] sum_c [3];
	logic [2:0] hit_c;

	assign job_ready = state_q == ST_IDLE;
	assign res.valid = res_valid_q;
	assign res.root_index = res_data_q;
	// output register free or draining this cycle
	assign res_load = (state_q == ST_DONE) && (!res_valid_q || res.ready);

	// operand select for the shared multiplier
	always_comb begin
		unique case (step_q)
			4'd0: begin op_a = 42'(x_q); op_b = 42'(x_q); end
			4'd1: begin op_a = 42'(y_q); op_b = 42'(y_q); end
			4'd2: begin op_a = 42'(x_q); op_b = 42'(y_q); end
			4'd3: begin op_a = 42'(z2r_q); op_b = 42'(x_q); end
			4'd4: begin op_a = 42'(z2i_q); op_b = 42'(y_q); end
			4'd5: begin op_a = 42'(z2r_q); op_b = 42'(y_q); end
			4'd6: begin op_a = 42'(z2i_q); op_b = 42'(x_q); end
			4'd7: begin op_a = 42'(dr_q); op_b = 42'(dr_q); end
			4'd8: begin op_a = 42'(di_q); op_b = 42'(di_q); end
			4'd9: begin op_a = fr_q; op_b = 42'(dr_q); end
			4'd10: begin op_a = fi_q; op_b = 42'(di_q); end
			4'd11: begin op_a = fi_q; op_b = 42'(dr_q); end
			4'd12: begin op_a = fr_q; op_b = 42'(di_q); end
			default: begin op_a = '0; op_b = '0; end
		endcase
	end

	always_comb begin
		a_mag = op_a[41] ? 42'(-op_a) : 42'(op_a);
		b_mag = op_b[41] ? 42'(-op_b) : 42'(op_b);
		dig = (phase_q == PH_LO) ? b_mag[20:0] : b_mag[41:21];
		pp = a_mag * dig;
		psign = op_a[41] ^ op_b[41];
		// z*z cross term is scaled by 2^27, the rest by 2^28
		rnd_sum = prod_q + ((step_q == 4'd2) ? RND27 : RND28);
		r_mag = (step_q == 4'd2) ? 44'(rnd_sum >> 27) : 44'(rnd_sum >> 28);
		r_s = psign ? -$signed(r_mag) : $signed(r_mag);
		p_s = psign ? -$signed(82'(prod_q)) : $signed(82'(prod_q));
	end

	// divider lanes, one quotient bit per cycle
	always_comb begin
		nmx = nr_q[81] ? -nr_q : nr_q;
		nmy = ni_q[81] ? -ni_q : ni_q;
		r2x = {remx_q, shx_q[7]};
		r2y = {remy_q, shy_q[7]};
		gex = r2x >= {1'b0, den_q};
		gey = r2y >= {1'b0, den_q};
		qsx = negx_q ? -$signed(45'(qx_q)) : $signed(45'(qx_q));
		qsy = negy_q ? -$signed(45'(qy_q)) : $signed(45'(qy_q));
	end

	// distance to each root, lanes in parallel
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dx = 34'(x_q) - 34'(ROOT_RE[k]);
			dy = 34'(y_q) - 34'(ROOT_IM[k]);
			mx = dx[33] ? 34'(-dx) : 34'(dx);
			my = dy[33] ? 34'(-dy) : 34'(dy);
			ux_c[k] = mx[15:0];
			uy_c[k] = my[15:0];
			ok_c[k] = (mx[33:16] == '0) && (my[33:16] == '0);
			sum_c[k] = 33'(ux_q[k]) * 33'(ux_q[k]) + 33'(uy_q[k]) * 33'(uy_q[k]);
			hit_c[k] = ok_q[k] && (sum_c[k] < 33'(tol2_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			phase_q <= PH_LO;
			cnt_q <= '0;
			iter_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) res_valid_q <= 1'b1;
			else if (res.ready) res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) state_q <= job.skip ? ST_DONE : ST_INIT;
				end
				ST_INIT: begin
					iter_q <= '0;
					state_q <= ST_TOP;
				end
				ST_TOP: begin
					step_q <= '0;
					phase_q <= PH_LO;
					state_q <= (iter_q == cfg.max_iterations) ? ST_DONE : ST_MUL;
				end
				ST_MUL: begin
					if (phase_q == PH_LO) begin
						phase_q <= PH_HI;
					end else if (phase_q == PH_HI) begin
						phase_q <= 2'd2;
					end else begin
						phase_q <= PH_LO;
						step_q <= step_q + 1'b1;
						if (step_q == 4'd2 && z2r_q == '0 && r_s == '0) state_q <= ST_DONE;
						else if (step_q == LAST_STEP) state_q <= ST_DINIT;
					end
				end
				ST_DINIT: begin
					cnt_q <= 6'(QUOT_BITS);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == 6'd1) state_q <= ST_DRND;
				end
				ST_DRND: state_q <= ST_UPD;
				ST_UPD: state_q <= ST_CHK1;
				ST_CHK1: state_q <= ST_CHK2;
				ST_CHK2: begin
					if (hit_c != '0) begin
						state_q <= ST_DONE;
					end else begin
						iter_q <= iter_q + 1'b1;
						state_q <= ST_TOP;
					end
				end
				ST_DONE: begin
					if (res_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q <= job.x0;
				y_q <= job.y0;
				result_q <= RES_NONE;
			end
			ST_INIT: tol2_q <= 32'(cfg.tolerance) * 32'(cfg.tolerance);
			ST_TOP: result_q <= RES_NONE;
			ST_MUL: begin
				if (phase_q == PH_LO) begin
					prod_q <= 84'(pp);
				end else if (phase_q == PH_HI) begin
					prod_q <= prod_q + {pp, 21'b0};
				end else begin
					case (step_q)
						4'd0, 4'd3, 4'd5: t_q <= r_s;
						4'd1: z2r_q <= 38'(t_q - r_s);
						4'd2: begin
							z2i_q <= 38'(r_s);
							dr_q <= 40'(z2r_q) + (40'(z2r_q) <<< 1);
							di_q <= 40'(r_s) + (40'(r_s) <<< 1);
						end
						4'd4: fr_q <= 42'(t_q - r_s - Q_ONE);
						4'd6: fi_q <= 42'(t_q + r_s);
						4'd7, 4'd9, 4'd11: acc_q <= p_s;
						4'd8: den_q <= 80'(acc_q + p_s);
						4'd10: nr_q <= acc_q + p_s;
						4'd12: ni_q <= acc_q - p_s;
						default: ;
					endcase
				end
			end
			ST_DINIT: begin
				capx_q <= {8'b0, 80'(nmx)} >= {den_q, 8'b0};
				capy_q <= {8'b0, 80'(nmy)} >= {den_q, 8'b0};
				remx_q <= 80'(nmx >>> 8);
				remy_q <= 80'(nmy >>> 8);
				shx_q <= nmx[7:0];
				shy_q <= nmy[7:0];
				negx_q <= nr_q[81];
				negy_q <= ni_q[81];
				qx_q <= '0;
				qy_q <= '0;
			end
			ST_DIV: begin
				remx_q <= gex ? 80'(r2x - {1'b0, den_q}) : 80'(r2x);
				remy_q <= gey ? 80'(r2y - {1'b0, den_q}) : 80'(r2y);
				qx_q <= {qx_q[QUOT_BITS-1:0], gex};
				qy_q <= {qy_q[QUOT_BITS-1:0], gey};
				shx_q <= {shx_q[6:0], 1'b0};
				shy_q <= {shy_q[6:0], 1'b0};
			end
			ST_DRND: begin
				// round half away from zero, or cap the step
				if (capx_q) qx_q <= QUOT_CAP;
				else if ({remx_q, 1'b0} >= {1'b0, den_q}) qx_q <= qx_q + 1'b1;
				if (capy_q) qy_q <= QUOT_CAP;
				else if ({remy_q, 1'b0} >= {1'b0, den_q}) qy_q <= qy_q + 1'b1;
			end
			ST_UPD: begin
				x_q <= sat32(45'(x_q) - qsx);
				y_q <= sat32(45'(y_q) - qsy);
			end
			ST_CHK1: begin
				ux_q <= ux_c;
				uy_q <= uy_c;
				ok_q <= ok_c;
			end
			ST_CHK2: begin
				if (hit_c[0]) result_q <= RES_ROOT1;
				else if (hit_c[1]) result_q <= RES_ROOT2;
				else if (hit_c[2]) result_q <= RES_ROOT3;
			end
			ST_DONE: begin
				if (res_load) res_data_q <= result_q;
			end
			default: ;
		endcase
	end

	a_iter_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (iter_q < cfg.max_iterations))
		else $error("newton step started beyond the iteration limit");

	a_quot_capped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |-> (qx_q <= QUOT_CAP && qy_q <= QUOT_CAP))
		else $error("quotient above cap");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q != '0))
		else $error("divider ran past its last bit");

	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result beat raised outside completion");
endmodule

// ===== hdl/newton_cubic_root_basin.sv =====
// newton_cubic_root_basin: top level, configuration registers, front end, queue, engine
// depends on ncrb_pkg, ncrb_ifs, ncrb_front, ncrb_fifo, ncrb_core
//
// Classifies each pixel beat (col, row) on the pix channel by the root of z^3-1 that
// Newton's method reaches from z = (x_min + col*x_step, y_min + row*y_step), and gives
// one root_index beat on the res channel: 0 for none, 1..3 for the roots in order.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must write them
// only while the block is idle, which the block itself does not enforce. The front end
// registers the start point and the queue holds up to two pixels, so pixels keep flowing
// in while the engine works. Each Newton step is thirteen products on one shared 42x21
// multiplier, each in a low half, high half and rounding phase, then a divider pair at
// one bit per cycle, then update and root test; up to max_iterations steps per pixel.
// Reset clears the channels and loads default registers; no memory needs clearing.
// A finished result waits in an output register while the engine takes the next pixel;
// with that register full the engine holds its next result until res.ready.
module newton_cubic_root_basin import ncrb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	ncrb_pix_if.sink pix,
	ncrb_res_if.source res,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	ncrb_cfg_t cfg_q;
	logic f_valid, f_ready, j_valid, j_ready;
	ncrb_job_t f_job, j_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_min <= RST_X_MIN;
			cfg_q.y_min <= RST_Y_MIN;
			cfg_q.x_step <= RST_X_STEP;
			cfg_q.y_step <= RST_Y_STEP;
			cfg_q.max_iterations <= RST_MAX_ITER;
			cfg_q.tolerance <= RST_TOL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_X_MIN: cfg_q.x_min <= $signed(cfg_data);
				CFG_Y_MIN: cfg_q.y_min <= $signed(cfg_data);
				CFG_X_STEP: cfg_q.x_step <= cfg_data[30:0];
				CFG_Y_STEP: cfg_q.y_step <= cfg_data[30:0];
				CFG_MAX_ITER: cfg_q.max_iterations <= cfg_data[15:0];
				CFG_TOL: cfg_q.tolerance <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	ncrb_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.pix(pix),
		.job_valid(f_valid),
		.job_ready(f_ready),
		.job(f_job)
	);

	ncrb_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_data(f_job),
		.pop_valid(j_valid),
		.pop_ready(j_ready),
		.pop_data(j_job)
	);

	ncrb_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.job_valid(j_valid),
		.job_ready(j_ready),
		.job(j_job),
		.res(res)
	);
endmodule
